>>> src/prc_pkg.sv
// Shared types and constants for the polyline rectangle clipper.
// Used by prc_ctrl, prc_datapath and polyline_rect_clip_top; no dependencies.
`timescale 1ns / 1ps

package prc_pkg;

  // Default coordinate width (signed fixed point, the binary point does not matter)
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH = 8;

  // Outcode bits
  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  // Number of clip steps before a segment is given up
  localparam logic [2:0] MAX_CLIPS = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WIN_LEFT   = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WIN_BOTTOM = 8'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WIN_RIGHT  = 8'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WIN_TOP    = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_HEAD,
    ST_TAIL
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_first;   // vertex opens a polyline
    logic load_seg;     // vertex closes a segment
    logic start_interp; // latch operands for one edge intersection
    logic mul_step;
    logic div_step;
    logic update_end;   // write intersection into the moving endpoint
    logic sel_head;     // present clipped start on the output
    logic commit;       // end point transferred: record tail
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first;        // incoming vertex starts a polyline
    logic accept;       // both outcodes zero
    logic reject;       // trivially outside, or out of clip steps
    logic mul_done;
    logic div_done;
    logic need_head;    // clipped start does not continue the open piece
  } status_t;

endpackage

>>> src/polyline_rect_clip_top.sv
// Top level of the polyline rectangle clipper.
// Instantiates prc_ctrl and prc_datapath; depends on prc_pkg.
`timescale 1ns / 1ps

// Streams polyline vertices and clips each segment to the window with
// Cohen-Sutherland outcodes, emitting pieces of clipped points. One vertex is
// worked on at a time. A segment is tested again after each clip step, and for
// each of up to prc_pkg::MAX_CLIPS edge intersections runs the bit-serial
// multiplier, the restoring divider and an update step; each result point
// is then held on the output until the sink takes it. Window writes go
// through cfg_index_i 0..3 (left, bottom, right, top); other indexes are
// ignored.
module polyline_rect_clip_top #(
  parameter int unsigned CoordWidth = prc_pkg::COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prc_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CoordWidth-1:0]             cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [CoordWidth-1:0]             vert_x_i,
  input  logic [CoordWidth-1:0]             vert_y_i,
  input  logic                              line_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [CoordWidth-1:0]             out_x_o,
  output logic [CoordWidth-1:0]             out_y_o,
  output logic                              piece_start_o,
  output logic                              last_of_item_o
);

  prc_pkg::cmd_t    cmd;
  prc_pkg::status_t status;

  assign cfg_ready_o    = 1'b1;
  assign piece_start_o  = cmd.sel_head;
  assign last_of_item_o = !cmd.sel_head;

  prc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  prc_datapath #(
    .CoordWidth (CoordWidth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .line_start_i (line_start_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o)
  );

endmodule

>>> src/prc_ctrl.sv
// Sequencing state machine for the polyline rectangle clipper.
// Depends on prc_pkg; drives prc_datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module prc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  prc_pkg::status_t status_i,
  output prc_pkg::cmd_t    cmd_o
);

  prc_pkg::state_e state_q, state_d;
  logic            in_xfer;
  logic            out_xfer;

  assign in_xfer  = in_valid_i && (state_q == prc_pkg::ST_IDLE);
  assign out_xfer = out_valid_o && !out_stall_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prc_pkg::ST_IDLE: begin
        if (in_xfer && !status_i.first) state_d = prc_pkg::ST_TEST;
      end
      prc_pkg::ST_TEST: begin
        if (status_i.accept) begin
          state_d = status_i.need_head ? prc_pkg::ST_HEAD : prc_pkg::ST_TAIL;
        end else if (status_i.reject) begin
          state_d = prc_pkg::ST_IDLE;
        end else begin
          state_d = prc_pkg::ST_MUL;
        end
      end
      prc_pkg::ST_MUL: begin
        if (status_i.mul_done) state_d = prc_pkg::ST_DIV;
      end
      prc_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = prc_pkg::ST_UPD;
      end
      prc_pkg::ST_UPD:  state_d = prc_pkg::ST_TEST;
      prc_pkg::ST_HEAD: begin
        if (out_xfer) state_d = prc_pkg::ST_TAIL;
      end
      prc_pkg::ST_TAIL: begin
        if (out_xfer) state_d = prc_pkg::ST_IDLE;
      end
      default: state_d = prc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != prc_pkg::ST_IDLE);
    out_valid_o = 1'b0;
    case (state_q)
      prc_pkg::ST_IDLE: begin
        cmd_o.load_first = in_xfer && status_i.first;
        cmd_o.load_seg   = in_xfer && !status_i.first;
      end
      prc_pkg::ST_TEST: begin
        cmd_o.start_interp = !status_i.accept && !status_i.reject;
      end
      prc_pkg::ST_MUL: cmd_o.mul_step = 1'b1;
      prc_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      prc_pkg::ST_UPD: cmd_o.update_end = 1'b1;
      prc_pkg::ST_HEAD: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_head = 1'b1;
      end
      prc_pkg::ST_TAIL: begin
        out_valid_o  = 1'b1;
        cmd_o.commit = out_xfer;
      end
      default: ;
    endcase
  end

endmodule

>>> src/prc_datapath.sv
// Datapath of the polyline rectangle clipper: window, vertex state, outcodes
// and a shift-add multiplier feeding a restoring divider. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_datapath #(
  parameter int unsigned CoordWidth = prc_pkg::COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prc_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CoordWidth-1:0]             cfg_data_i,
  input  logic [CoordWidth-1:0]             vert_x_i,
  input  logic [CoordWidth-1:0]             vert_y_i,
  input  logic                              line_start_i,
  input  prc_pkg::cmd_t                     cmd_i,
  output prc_pkg::status_t                  status_o,
  output logic [CoordWidth-1:0]             out_x_o,
  output logic [CoordWidth-1:0]             out_y_o
);

  localparam int unsigned W  = CoordWidth;
  localparam int unsigned DW = CoordWidth + 1;  // magnitude of a difference
  localparam int unsigned PW = 2 * DW;          // product / dividend
  localparam int unsigned CW = $clog2(PW + 1);
  localparam logic [CW-1:0] MulLast = CW'(DW - 1);
  localparam logic [CW-1:0] DivLast = CW'(PW - 1);

  logic signed [W-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
  logic signed [W-1:0] prev_x_q, prev_y_q, tail_x_q, tail_y_q;
  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic                have_prev_q, piece_open_q;
  logic [2:0]          clips_q;

  // Intersection unit state
  logic                horiz_q;    // top/bottom edge: y set to edge, x computed
  logic                mv_end_q;   // 1: endpoint 1 moves
  logic signed [W-1:0] edge_q;
  logic signed [W-1:0] a0_q;
  logic                neg_q;
  logic [DW-1:0]       m2_q, m3_q, rem_q;
  logic [PW-1:0]       mcand_q, prod_q;
  logic [CW-1:0]       cnt_q;

  logic [3:0] c0, c1, co;

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_bottom_q <= '0;
      win_right_q  <= '0;
      win_top_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prc_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        prc_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        prc_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        prc_pkg::REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Outcodes of the two working endpoints
  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x, input logic signed [W-1:0] y,
    input logic signed [W-1:0] l, input logic signed [W-1:0] r,
    input logic signed [W-1:0] b, input logic signed [W-1:0] t);
    logic [3:0] c;
    c = '0;
    if (x < l)      c = c | prc_pkg::OC_LEFT;
    else if (x > r) c = c | prc_pkg::OC_RIGHT;
    if (y < b)      c = c | prc_pkg::OC_BOTTOM;
    else if (y > t) c = c | prc_pkg::OC_TOP;
    return c;
  endfunction

  assign c0 = outcode(x0_q, y0_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
  assign c1 = outcode(x1_q, y1_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
  assign co = (c0 != 4'd0) ? c0 : c1;

  // Operand selection for the next intersection
  logic                use_h;
  logic signed [W-1:0] sa0, sa1, sb0, sb1, se;
  logic signed [DW-1:0] d1, d2, d3;

  always_comb begin
    use_h = (co & (prc_pkg::OC_TOP | prc_pkg::OC_BOTTOM)) != 4'd0;
    if (use_h) begin
      sa0 = x0_q; sa1 = x1_q; sb0 = y0_q; sb1 = y1_q;
      se  = ((co & prc_pkg::OC_TOP) != 4'd0) ? win_top_q : win_bottom_q;
    end else begin
      sa0 = y0_q; sa1 = y1_q; sb0 = x0_q; sb1 = x1_q;
      se  = ((co & prc_pkg::OC_RIGHT) != 4'd0) ? win_right_q : win_left_q;
    end
    d1 = $signed({sa1[W-1], sa1}) - $signed({sa0[W-1], sa0});
    d2 = $signed({se[W-1], se})   - $signed({sb0[W-1], sb0});
    d3 = $signed({sb1[W-1], sb1}) - $signed({sb0[W-1], sb0});
  end

  // Divider step
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_nx;

  assign rem_sh = {rem_q, prod_q[PW-1]};
  assign ge     = rem_sh >= {1'b0, m3_q};
  assign rem_nx = ge ? DW'(rem_sh - {1'b0, m3_q}) : rem_sh[DW-1:0];

  // Final coordinate: a0 plus signed quotient, wrapped
  logic [W-1:0]        quo;
  logic signed [W-1:0] res;

  assign quo = prod_q[W-1:0];
  assign res = (m3_q == '0) ? a0_q : (a0_q + (neg_q ? (W'(0) - quo) : quo));

  // Intersection unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start_interp) begin
      cnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      cnt_q <= (cnt_q == MulLast) ? '0 : cnt_q + CW'(1);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_interp) begin
      horiz_q  <= use_h;
      mv_end_q <= (c0 == 4'd0);
      edge_q   <= se;
      a0_q     <= sa0;
      neg_q    <= d1[DW-1] ^ d2[DW-1] ^ d3[DW-1];
      mcand_q  <= PW'(d1[DW-1] ? (DW'(0) - d1) : d1);
      m2_q     <= d2[DW-1] ? (DW'(0) - d2) : d2;
      m3_q     <= d3[DW-1] ? (DW'(0) - d3) : d3;
      prod_q   <= '0;
      rem_q    <= '0;
    end else if (cmd_i.mul_step) begin
      if (m2_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q <= {mcand_q[PW-2:0], 1'b0};
      m2_q    <= {1'b0, m2_q[DW-1:1]};
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_nx;
      prod_q <= {prod_q[PW-2:0], ge};
    end
  end

  // Vertex and piece state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      piece_open_q <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      tail_x_q     <= '0;
      tail_y_q     <= '0;
      clips_q      <= '0;
    end else begin
      if (cmd_i.load_first || cmd_i.load_seg) begin
        prev_x_q    <= vert_x_i;
        prev_y_q    <= vert_y_i;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.load_first) piece_open_q <= 1'b0;
      if (cmd_i.load_seg) clips_q <= '0;
      if (cmd_i.update_end) clips_q <= clips_q + 3'd1;
      if (cmd_i.commit) begin
        tail_x_q     <= x1_q;
        tail_y_q     <= y1_q;
        piece_open_q <= 1'b1;
      end
    end
  end

  // Working segment endpoints
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seg) begin
      x0_q <= prev_x_q;
      y0_q <= prev_y_q;
      x1_q <= vert_x_i;
      y1_q <= vert_y_i;
    end else if (cmd_i.update_end) begin
      if (mv_end_q) begin
        x1_q <= horiz_q ? res : edge_q;
        y1_q <= horiz_q ? edge_q : res;
      end else begin
        x0_q <= horiz_q ? res : edge_q;
        y0_q <= horiz_q ? edge_q : res;
      end
    end
  end

  // Status
  assign status_o.first     = line_start_i || !have_prev_q;
  assign status_o.accept    = (c0 | c1) == 4'd0;
  assign status_o.reject    = ((c0 & c1) != 4'd0) || (clips_q == prc_pkg::MAX_CLIPS);
  assign status_o.mul_done  = cmd_i.mul_step && (cnt_q == MulLast);
  assign status_o.div_done  = cmd_i.div_step && (cnt_q == DivLast);
  assign status_o.need_head = !piece_open_q || (tail_x_q != x0_q) || (tail_y_q != y0_q);

  // Result point
  assign out_x_o = cmd_i.sel_head ? x0_q : x1_q;
  assign out_y_o = cmd_i.sel_head ? y0_q : y1_q;

endmodule
